// File: src/ivslc_pkg.sv
package ivslc_pkg;

    localparam int POINTS_DEF = 32;
    localparam int CODE_W = 12;
    localparam int IDX_W = 6;
    localparam int V_W = 23;
    localparam int SCALE_W = 18;
    localparam int GAIN_W = 16;
    localparam int CFG_W = 18;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'd1;
    localparam logic [SCALE_W-1:0] SCALE_RST = 18'd68985;
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd8872;
    localparam logic [CODE_W-1:0] CODE_MAX = 12'd4095;
    localparam logic [CODE_W-1:0] DEAD_OFFSET = 12'd1152;
    localparam int DIV_W = 39;
    localparam int DEN_W = 24;

    typedef struct packed {
        logic [22:0] open_voltage_uv;
        logic [22:0] short_voltage_uv;
        logic [11:0] midpoint_code;
    } in_word_t;

    typedef struct packed {
        logic [5:0]  point_index;
        logic [11:0] dac_code;
        logic        last_point;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_POINT,
        ST_VOLT,
        ST_DEN,
        ST_DIV,
        ST_NORM,
        ST_SQR,
        ST_GAIN,
        ST_CODE,
        ST_EMIT
    } state_t;

endpackage

// File: src/iv_sweep_load_curve_generator.sv
// Load-curve generator: one start word (open-circuit voltage, short voltage,
// midpoint code) yields POINTS result words on result/result_valid, each held
// one cycle; the receiver cannot stall. Point 0 is code 0, the last is 4095.
// busy stays high from the accepting edge until the last word is on the port.
// step=(oc-sc)/(POINTS-1) runs on a shared 39-bit restoring divider; the
// first word then passes through ST_STEP and ST_EMIT to the port.
// Each inner point uses the same divider, a one-bit-a-cycle normalize (its
// length set by the size of the ratio) and 12 squarings on one
// multiplier. A dead denominator skips the divider, normalize and squarings;
// a dead ratio skips normalize and squarings.
module iv_sweep_load_curve_generator #(
    parameter int POINTS = ivslc_pkg::POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  ivslc_pkg::in_word_t                 operand,
    output logic                                busy,
    output logic                                result_valid,
    output ivslc_pkg::out_word_t                result,
    input  logic                                cfg_we,
    input  logic [ivslc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ivslc_pkg::CFG_W-1:0]         cfg_data
);

    localparam int DW = ivslc_pkg::DIV_W;
    localparam int DC_W = $clog2(DW + 1);
    localparam logic [ivslc_pkg::IDX_W-1:0] LAST = ivslc_pkg::IDX_W'(POINTS - 1);
    localparam logic [ivslc_pkg::IDX_W-1:0] HALF = ivslc_pkg::IDX_W'(POINTS / 2);

    ivslc_pkg::state_t state_reg, state_next;
    logic [ivslc_pkg::SCALE_W-1:0] scale_reg;
    logic [ivslc_pkg::GAIN_W-1:0]  gain_reg;
    logic [22:0] oc_reg, oc_next, sc_reg, sc_next, step_reg, step_next;
    logic [22:0] v_reg, v_next;
    logic [11:0] mid_reg, mid_next, prev_reg, prev_next;
    logic [ivslc_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [DW-1:0] quo_reg, quo_next, rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [DC_W-1:0] cnt_reg, cnt_next;
    logic div_step_reg, div_step_next;
    logic [46:0] acc_reg, acc_next;
    logic [5:0] msb_reg, msb_next;
    logic [11:0] frac_reg, frac_next;
    logic signed [19:0] raw_reg, raw_next;
    logic valid_reg, valid_next;
    ivslc_pkg::out_word_t res_reg, res_next;

    logic [DW:0] trial;
    logic [63:0] sq;
    logic [40:0] vprod;
    logic signed [34:0] gprod;
    logic signed [17:0] lq;
    logic signed [19:0] rawc;
    logic [12:0] inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= ivslc_pkg::SCALE_RST;
            gain_reg  <= ivslc_pkg::GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ivslc_pkg::REG_SCALE: scale_reg <= cfg_data[ivslc_pkg::SCALE_W-1:0];
                ivslc_pkg::REG_GAIN:  gain_reg  <= cfg_data[ivslc_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ivslc_pkg::ST_IDLE;
            valid_reg <= 1'b0;
            prev_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            prev_reg  <= prev_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oc_reg <= oc_next; sc_reg <= sc_next; step_reg <= step_next; mid_reg <= mid_next;
        quo_reg <= quo_next; rem_reg <= rem_next; dvs_reg <= dvs_next; cnt_reg <= cnt_next;
        div_step_reg <= div_step_next; v_reg <= v_next;
        acc_reg <= acc_next; msb_reg <= msb_next; frac_reg <= frac_next;
        raw_reg <= raw_next; res_reg <= res_next;
    end

    assign busy = (state_reg != ivslc_pkg::ST_IDLE);
    assign result_valid = valid_reg;
    assign result = res_reg;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DW-1]} - {1'b0, dvs_reg};
        sq = acc_reg[31:0] * acc_reg[31:0];
        vprod = {18'd0, v_reg} * {23'd0, scale_reg};
        lq = ($signed({12'd0, msb_reg}) - 18'sd16) * 18'sd4096 + $signed({6'd0, frac_reg});
        gprod = 35'(lq) * 35'($signed({1'b0, gain_reg}));
        rawc = 20'(signed'({8'd0, mid_reg})) + 20'(gprod >>> 20);
        inc = {1'b0, prev_reg} + 13'd2;

        state_next = state_reg;
        oc_next = oc_reg; sc_next = sc_reg; step_next = step_reg; mid_next = mid_reg;
        quo_next = quo_reg; rem_next = rem_reg; dvs_next = dvs_reg; cnt_next = cnt_reg;
        div_step_next = div_step_reg; v_next = v_reg;
        acc_next = acc_reg; msb_next = msb_reg; frac_next = frac_reg;
        raw_next = raw_reg; res_next = res_reg;
        prev_next = prev_reg; idx_next = idx_reg;
        valid_next = 1'b0;

        unique case (state_reg)
            ivslc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    oc_next = operand.open_voltage_uv;
                    sc_next = (operand.short_voltage_uv > operand.open_voltage_uv) ?
                              operand.open_voltage_uv : operand.short_voltage_uv;
                    mid_next = operand.midpoint_code;
                    quo_next = DW'(operand.open_voltage_uv - sc_next);
                    rem_next = '0;
                    dvs_next = DW'(POINTS - 1);
                    cnt_next = DC_W'(DW);
                    idx_next = '0;
                    div_step_next = 1'b1;
                    state_next = ivslc_pkg::ST_DIV;
                end
            end
            ivslc_pkg::ST_DIV:
            begin
                if (trial[DW])
                begin
                    rem_next = {rem_reg[DW-2:0], quo_reg[DW-1]};
                    quo_next = {quo_reg[DW-2:0], 1'b0};
                end
                else
                begin
                    rem_next = trial[DW-1:0];
                    quo_next = {quo_reg[DW-2:0], 1'b1};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == DC_W'(1))
                    state_next = div_step_reg ? ivslc_pkg::ST_STEP : ivslc_pkg::ST_NORM;
            end
            ivslc_pkg::ST_STEP:
            begin
                step_next = quo_reg[22:0];
                // sc + (POINTS-1)*step is oc less the remainder
                v_next = oc_reg - rem_reg[22:0];
                res_next = '{point_index: '0, dac_code: '0, last_point: 1'b0};
                state_next = ivslc_pkg::ST_EMIT;
            end
            ivslc_pkg::ST_POINT:
            begin
                if (idx_reg == LAST)
                begin
                    res_next = '{point_index: idx_reg, dac_code: ivslc_pkg::CODE_MAX,
                                 last_point: 1'b1};
                    state_next = ivslc_pkg::ST_EMIT;
                end
                else
                    state_next = ivslc_pkg::ST_VOLT;
            end
            ivslc_pkg::ST_VOLT:
            begin
                acc_next = 47'(vprod >> 16);
                state_next = ivslc_pkg::ST_DEN;
            end
            ivslc_pkg::ST_DEN:
            begin
                if (acc_reg <= 47'(sc_reg))
                begin
                    raw_next = 20'(signed'({8'd0, mid_reg})) -
                               20'(signed'({8'd0, ivslc_pkg::DEAD_OFFSET}));
                    state_next = ivslc_pkg::ST_CODE;
                    msb_next = '0;
                end
                else
                begin
                    dvs_next = DW'(acc_reg - 47'(sc_reg));
                    quo_next = {oc_reg, 16'd0};
                    rem_next = '0;
                    cnt_next = DC_W'(DW);
                    div_step_next = 1'b0;
                    state_next = ivslc_pkg::ST_DIV;
                end
            end
            ivslc_pkg::ST_NORM:
            begin
                if (cnt_reg == '0)
                begin
                    if (quo_reg <= DW'(65536))
                    begin
                        raw_next = 20'(signed'({8'd0, mid_reg})) -
                                   20'(signed'({8'd0, ivslc_pkg::DEAD_OFFSET}));
                        msb_next = '0;
                        state_next = ivslc_pkg::ST_CODE;
                    end
                    else
                    begin
                        acc_next = 47'(quo_reg - DW'(65536));
                        msb_next = 6'd46;
                        cnt_next = DC_W'(1);
                    end
                end
                else if (acc_reg[46])
                begin
                    acc_next = 47'(acc_reg[46:16]);
                    cnt_next = DC_W'(12);
                    frac_next = '0;
                    state_next = ivslc_pkg::ST_SQR;
                end
                else
                begin
                    acc_next = {acc_reg[45:0], 1'b0};
                    msb_next = msb_reg - 1'b1;
                end
            end
            ivslc_pkg::ST_SQR:
            begin
                if (sq[61])
                begin
                    acc_next = 47'(sq[62:31]);
                    frac_next = {frac_reg[10:0], 1'b1};
                end
                else
                begin
                    acc_next = 47'(sq[61:30]);
                    frac_next = {frac_reg[10:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == DC_W'(1))
                    state_next = ivslc_pkg::ST_GAIN;
            end
            ivslc_pkg::ST_GAIN:
            begin
                raw_next = rawc;
                state_next = ivslc_pkg::ST_CODE;
            end
            ivslc_pkg::ST_CODE:
            begin
                res_next.point_index = idx_reg;
                res_next.last_point = 1'b0;
                if (raw_reg <= 20'sd0)
                    res_next.dac_code = '0;
                else if (raw_reg > 20'sd4095)
                    res_next.dac_code = ivslc_pkg::CODE_MAX;
                else if (idx_reg >= HALF && idx_reg < LAST - 6'd1)
                    res_next.dac_code = inc[12] ? ivslc_pkg::CODE_MAX : inc[11:0];
                else
                    res_next.dac_code = raw_reg[11:0];
                state_next = ivslc_pkg::ST_EMIT;
            end
            ivslc_pkg::ST_EMIT:
            begin
                valid_next = 1'b1;
                prev_next = res_reg.dac_code;
                idx_next = res_reg.point_index;
                v_next = v_reg - step_reg;
                if (res_reg.last_point)
                    state_next = ivslc_pkg::ST_IDLE;
                else
                begin
                    idx_next = res_reg.point_index + 1'b1;
                    state_next = ivslc_pkg::ST_POINT;
                end
            end
            default: state_next = ivslc_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = ivslc_pkg::POINTS_DEF;
    localparam int WDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS = 60;

    class curve_scoreboard;
        ivslc_pkg::out_word_t pending[$];
        logic [ivslc_pkg::SCALE_W-1:0] scale;
        logic [ivslc_pkg::GAIN_W-1:0] gain;
        logic [ivslc_pkg::CODE_W-1:0] prev_code;
        int errors;
        int words_checked;

        function new();
            scale = ivslc_pkg::SCALE_RST;
            gain = ivslc_pkg::GAIN_RST;
            prev_code = '0;
            errors = 0;
            words_checked = 0;
        endfunction

        function automatic longint log2_q12(longint unsigned r);
            int msb;
            longint unsigned t;
            longint unsigned mant;
            longint frac;
            msb = 0;
            t = r;
            frac = 0;
            while (t > 1)
            begin
                t = t >> 1;
                msb++;
            end
            if (msb > 30)
                mant = r >> (msb - 30);
            else
                mant = r << (30 - msb);
            for (int k = 0; k < 12; k++)
            begin
                mant = (mant * mant) >> 30;
                frac = frac << 1;
                if (mant >= (64'd1 << 31))
                begin
                    frac = frac | 1;
                    mant = mant >> 1;
                end
            end
            return (longint'(msb) - 16) * 4096 + frac;
        endfunction

        function automatic void note_start(ivslc_pkg::in_word_t w);
            longint unsigned oc, sc, stp, v;
            longint d, r, mid, raw;
            logic [ivslc_pkg::CODE_W-1:0] code;
            ivslc_pkg::out_word_t e;
            oc = w.open_voltage_uv;
            sc = w.short_voltage_uv;
            mid = w.midpoint_code;
            if (sc > oc)
                sc = oc;
            stp = (oc - sc) / (NPTS - 1);
            for (int i = 0; i < NPTS; i++)
            begin
                if (i == 0)
                    code = '0;
                else if (i == NPTS - 1)
                    code = ivslc_pkg::CODE_MAX;
                else
                begin
                    v = sc + longint'(NPTS - 1 - i) * stp;
                    d = longint'((v * longint'(scale)) >> 16) - longint'(sc);
                    if (d <= 0)
                        raw = mid - longint'(ivslc_pkg::DEAD_OFFSET);
                    else
                    begin
                        r = longint'((oc << 16) / d) - 65536;
                        if (r <= 0)
                            raw = mid - longint'(ivslc_pkg::DEAD_OFFSET);
                        else
                            raw = mid + ((log2_q12(r) * longint'(gain)) >>> 20);
                    end
                    if (raw <= 0)
                        code = '0;
                    else if (raw > longint'(ivslc_pkg::CODE_MAX))
                        code = ivslc_pkg::CODE_MAX;
                    else if (i >= NPTS / 2 && i < NPTS - 2)
                        code = (prev_code > ivslc_pkg::CODE_MAX - 12'd2) ?
                               ivslc_pkg::CODE_MAX : prev_code + 12'd2;
                    else
                        code = raw[ivslc_pkg::CODE_W-1:0];
                end
                prev_code = code;
                e.point_index = i[ivslc_pkg::IDX_W-1:0];
                e.dac_code = code;
                e.last_point = (i == NPTS - 1);
                pending.push_back(e);
            end
        endfunction

        function automatic void check_word(ivslc_pkg::out_word_t got);
            ivslc_pkg::out_word_t e;
            words_checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.point_index !== e.point_index || got.dac_code !== e.dac_code ||
                got.last_point !== e.last_point)
            begin
                $display("%0t: mismatch expected idx=%0d code=%0d last=%0b got idx=%0d code=%0d last=%0b",
                         $time, e.point_index, e.dac_code, e.last_point,
                         got.point_index, got.dac_code, got.last_point);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    ivslc_pkg::in_word_t operand;
    logic busy;
    logic result_valid;
    ivslc_pkg::out_word_t result;
    logic cfg_we;
    logic [ivslc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ivslc_pkg::CFG_W-1:0] cfg_data;

    curve_scoreboard sb;
    int wdog;
    int items_sent;
    bit no_idle;

    iv_sweep_load_curve_generator u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .operand(operand),
        .busy(busy),
        .result_valid(result_valid),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_word(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || result_valid || (start && !busy))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_word(ivslc_pkg::in_word_t w);
        while (!no_idle && $urandom_range(0, 99) < 23)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        operand <= w;
        do
            @(posedge clk);
        while (busy);
        sb.note_start(w);
        items_sent++;
    endtask

    task automatic write_regs(logic [ivslc_pkg::CFG_W-1:0] scale_val,
                              logic [ivslc_pkg::CFG_W-1:0] gain_val);
        start <= 1'b0;
        while (sb.pending.size() != 0 || busy)
            @(posedge clk);
        repeat (5) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= ivslc_pkg::REG_SCALE;
        cfg_data <= scale_val;
        @(posedge clk);
        sb.scale = scale_val[ivslc_pkg::SCALE_W-1:0];
        cfg_index <= ivslc_pkg::REG_GAIN;
        cfg_data <= gain_val;
        @(posedge clk);
        sb.gain = gain_val[ivslc_pkg::GAIN_W-1:0];
        cfg_we <= 1'b0;
    endtask

    function automatic ivslc_pkg::in_word_t mk(int unsigned oc, int unsigned sc,
                                               int unsigned mid);
        ivslc_pkg::in_word_t w;
        w.open_voltage_uv = oc[ivslc_pkg::V_W-1:0];
        w.short_voltage_uv = sc[ivslc_pkg::V_W-1:0];
        w.midpoint_code = mid[ivslc_pkg::CODE_W-1:0];
        return w;
    endfunction

    function automatic ivslc_pkg::in_word_t rand_word();
        int unsigned oc, sc;
        case ($urandom_range(0, 9))
            0: return mk($urandom, $urandom, $urandom);
            1:
            begin
                sc = $urandom_range(1, 6600000);
                return mk($urandom_range(0, sc - 1), sc, $urandom);
            end
            default:
            begin
                oc = $urandom_range(0, 6600000);
                sc = $urandom_range(0, oc);
                return mk(oc, sc, $urandom);
            end
        endcase
    endfunction

    initial
    begin
        logic [ivslc_pkg::CFG_W-1:0] scales[5];
        logic [ivslc_pkg::CFG_W-1:0] gains[5];
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        operand = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        wdog = 0;
        items_sent = 0;
        no_idle = 0;
        scales = '{ivslc_pkg::SCALE_RST, 18'd65536, 18'd131072, 18'd0, 18'h3FFFF};
        gains = '{18'(ivslc_pkg::GAIN_RST), 18'd0, 18'h3FFFF, 18'($urandom),
                  18'($urandom)};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(mk(0, 0, 0));
        send_word(mk(6600000, 0, 2048));
        send_word(mk(6600000, 0, 4095));
        send_word(mk(6600000, 0, 0));
        send_word(mk(3000000, 5000000, 1000));
        send_word(mk(4000000, 4000000, 3000));
        send_word(mk(23'h7FFFFF, 23'h7FFFFF, 12'hFFF));
        send_word(mk(23'h7FFFFF, 0, 12'h800));
        send_word(mk(0, 23'h7FFFFF, 12'h555));
        send_word(mk(5000000, 1000000, 1152));
        send_word(mk(5000000, 4900000, 1153));
        send_word(mk(31, 0, 1500));
        send_word(mk(2500000, 100, 2500));

        for (int p = 0; p < 5; p++)
        begin
            if (p > 0)
                write_regs(scales[p], gains[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                no_idle = (p == 1 && n < 40);
                send_word(rand_word());
            end
        end
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("sent %0d start words, checked %0d result words over 5 register settings",
                 items_sent, sb.words_checked);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// File: sim.f
src/ivslc_pkg.sv
src/iv_sweep_load_curve_generator.sv
sim/tb.sv
